### rtl/rnfa_pkg.sv
// ----------------------------------------------------------------------------
// rnfa_pkg: shared types and constants of the ring neighbour FIFO arbiter
// Client states, event opcodes, controller states and the control bundle
// that the arbiter hands to every queue cell.
// ----------------------------------------------------------------------------
package rnfa_pkg;

    localparam int OPCODE_W   = 2;
    localparam int CLIENT_W   = 4;
    localparam int COUNT_W    = 5;
    localparam int MAX_GRANTS = 8;
    localparam int GRANT_W    = $clog2(MAX_GRANTS + 1);

    typedef enum logic [1:0] {
        ST_THINK = 2'd0,
        ST_WAIT  = 2'd1,
        ST_EAT   = 2'd2
    } t_status;

    typedef enum logic [OPCODE_W-1:0] {
        OP_REQUEST  = 2'd0,
        OP_RELEASE  = 2'd1,
        OP_WITHDRAW = 2'd2
    } t_opcode;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    typedef struct packed {
        logic                append;
        logic                remove;
        logic                withdraw;
        logic [CLIENT_W-1:0] client;
    } t_cell_ctl;

endpackage

### rtl/rnfa_in_if.sv
// ----------------------------------------------------------------------------
// rnfa_in_if: event request channel
// Valid/ready channel that carries one arbiter event.
// ----------------------------------------------------------------------------
interface rnfa_in_if;

    logic                          valid;
    logic                          ready;
    logic [rnfa_pkg::OPCODE_W-1:0] opcode;
    logic [rnfa_pkg::CLIENT_W-1:0] client;

    modport source (output valid, output opcode, output client, input ready);
    modport sink   (input valid, input opcode, input client, output ready);

endinterface

### rtl/rnfa_out_if.sv
// ----------------------------------------------------------------------------
// rnfa_out_if: grant result channel
// Valid/ready channel that carries one grant result of the arbiter.
// ----------------------------------------------------------------------------
interface rnfa_out_if;

    logic                          valid;
    logic                          ready;
    logic                          grant_valid;
    logic [rnfa_pkg::CLIENT_W-1:0] granted_client;
    logic                          ignored;
    logic [rnfa_pkg::COUNT_W-1:0]  queue_count;
    logic                          last;

    modport source (output valid, output grant_valid, output granted_client,
                    output ignored, output queue_count, output last, input ready);
    modport sink   (input valid, input grant_valid, input granted_client,
                    input ignored, input queue_count, input last, output ready);

endinterface

### rtl/rnfa_cell.sv
// ----------------------------------------------------------------------------
// rnfa_cell: one slot of the wait queue
// Holds one queued client, flags it when it may eat or when it is being
// withdrawn, passes the first hit down the row and closes the gap by taking
// the id of the next slot.
// ----------------------------------------------------------------------------
module rnfa_cell #(
    parameter int CLIENTS = 5
) (
    input  logic                          i_clk,
    input  rnfa_pkg::t_cell_ctl           i_ctl,
    input  logic [CLIENTS-1:0]            i_eat,
    input  logic                          i_occupied,
    input  logic                          i_is_tail,
    input  logic                          i_hit_seen,
    input  logic [$clog2(CLIENTS)-1:0]    i_sel_id,
    input  logic [$clog2(CLIENTS)-1:0]    i_next_id,
    output logic                          o_hit_seen,
    output logic [$clog2(CLIENTS)-1:0]    o_sel_id,
    output logic [$clog2(CLIENTS)-1:0]    o_id
);

    localparam int IdW = $clog2(CLIENTS);

    logic [IdW-1:0] r_id;
    logic [IdW-1:0] n_id;
    logic [IdW-1:0] w_left;
    logic [IdW-1:0] w_right;
    logic           w_eligible;
    logic           w_match;
    logic           w_hit;

    always_comb begin
        w_left     = (r_id == '0) ? IdW'(CLIENTS - 1) : r_id - 1'b1;
        w_right    = (r_id == IdW'(CLIENTS - 1)) ? '0 : r_id + 1'b1;
        w_eligible = i_occupied && !i_eat[w_left] && !i_eat[w_right];
        w_match    = i_occupied && (r_id == i_ctl.client[IdW-1:0]);
        w_hit      = i_ctl.withdraw ? w_match : w_eligible;
        o_hit_seen = i_hit_seen || w_hit;
        o_sel_id   = (!i_hit_seen && w_hit) ? r_id : i_sel_id;
        o_id       = r_id;

        n_id = r_id;
        if (i_ctl.remove && o_hit_seen) begin
            n_id = i_next_id;
        end
        if (i_ctl.append && i_is_tail) begin
            n_id = i_ctl.client[IdW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

endmodule

### rtl/ring_neighbour_fifo_arbiter.sv
// ----------------------------------------------------------------------------
// ring_neighbour_fifo_arbiter: waiter arbiter for clients in a ring
// Takes request, release and withdraw events and grants waiting clients
// whose two ring neighbours are not eating, oldest first.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one event (opcode, client). It is taken only while the
//   arbiter is idle; the event is applied in the cycle it is accepted.
//   o_rsp carries the results: one per grant, or a single no-grant result,
//   with last set on the final result of the event.
//   Each scan step of the queue cell row yields one grant per cycle while the
//   output register is free; a grant is held pending and is issued as a
//   result on the next scan step, and the scan ends with the step that finds
//   nothing.
//   A result waits in the output register; while it is not taken the scan
//   holds, and the next event is taken once the previous scan is done.
//   Reset makes every client thinking and empties the queue.
// ----------------------------------------------------------------------------
module ring_neighbour_fifo_arbiter #(
    parameter int CLIENTS = 5
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rnfa_in_if.sink   i_req,
    rnfa_out_if.source o_rsp
);

    localparam int IdW     = $clog2(CLIENTS);
    localparam int CntW    = $clog2(CLIENTS + 1);
    localparam int ClientW = rnfa_pkg::CLIENT_W;
    localparam int CountW  = rnfa_pkg::COUNT_W;
    localparam int GrantW  = rnfa_pkg::GRANT_W;

    rnfa_pkg::t_state    r_state, n_state;
    rnfa_pkg::t_status   r_status [CLIENTS];
    rnfa_pkg::t_status   n_status [CLIENTS];
    logic [CntW-1:0]     r_count, n_count;
    logic [GrantW-1:0]   r_ngrant, n_ngrant;
    logic                r_ign, n_ign;
    logic                r_pend_valid, n_pend_valid;
    logic [IdW-1:0]      r_pend_client, n_pend_client;
    logic [CntW-1:0]     r_pend_count, n_pend_count;
    logic                r_out_valid, n_out_valid;
    logic                r_out_grant, n_out_grant;
    logic [ClientW-1:0]  r_out_client, n_out_client;
    logic                r_out_ign, n_out_ign;
    logic [CntW-1:0]     r_out_count, n_out_count;
    logic                r_out_last, n_out_last;

    rnfa_pkg::t_cell_ctl w_ctl;
    logic [CLIENTS-1:0]  w_eat;
    logic [CLIENTS-1:0]  w_occ;
    logic [CLIENTS-1:0]  w_tail;
    logic                w_hit_seen [CLIENTS+1];
    logic [IdW-1:0]      w_sel_id   [CLIENTS+1];
    logic [IdW-1:0]      w_id       [CLIENTS];
    logic                w_accept;
    logic                w_in_range;
    logic [IdW-1:0]      w_idx;
    logic                w_req_ok;
    logic                w_rel_ok;
    logic                w_wdr_ok;
    logic                w_out_free;
    logic                w_advance;
    logic                w_found;
    logic [IdW-1:0]      w_granted;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_in_range = ({1'b0, i_req.client} < (ClientW + 1)'(CLIENTS));
    assign w_idx      = i_req.client[IdW-1:0];
    assign w_req_ok   = w_in_range && (i_req.opcode == rnfa_pkg::OP_REQUEST)
                        && (r_status[w_idx] == rnfa_pkg::ST_THINK)
                        && (r_count < CntW'(CLIENTS));
    assign w_rel_ok   = w_in_range && (i_req.opcode == rnfa_pkg::OP_RELEASE)
                        && (r_status[w_idx] == rnfa_pkg::ST_EAT);
    assign w_wdr_ok   = w_in_range && (i_req.opcode == rnfa_pkg::OP_WITHDRAW)
                        && (r_status[w_idx] == rnfa_pkg::ST_WAIT);

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_advance  = (r_state == rnfa_pkg::S_SCAN) && w_out_free;
    assign w_found    = w_hit_seen[CLIENTS] && (r_ngrant < GrantW'(rnfa_pkg::MAX_GRANTS));
    assign w_granted  = w_sel_id[CLIENTS];

    always_comb begin
        w_ctl.append   = w_accept && w_req_ok;
        w_ctl.withdraw = (r_state == rnfa_pkg::S_IDLE);
        w_ctl.remove   = (w_accept && w_wdr_ok) || (w_advance && w_found);
        w_ctl.client   = i_req.client;
    end

    assign w_hit_seen[0] = 1'b0;
    assign w_sel_id[0]   = '0;

    for (genvar k = 0; k < CLIENTS; k++) begin : g_cell
        assign w_eat[k]  = (r_status[k] == rnfa_pkg::ST_EAT);
        assign w_occ[k]  = (r_count > CntW'(k));
        assign w_tail[k] = (r_count == CntW'(k));

        rnfa_cell #(
            .CLIENTS (CLIENTS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_eat      (w_eat),
            .i_occupied (w_occ[k]),
            .i_is_tail  (w_tail[k]),
            .i_hit_seen (w_hit_seen[k]),
            .i_sel_id   (w_sel_id[k]),
            .i_next_id  ((k == CLIENTS - 1) ? w_id[k] : w_id[(k + 1) % CLIENTS]),
            .o_hit_seen (w_hit_seen[k+1]),
            .o_sel_id   (w_sel_id[k+1]),
            .o_id       (w_id[k])
        );
    end

    always_comb begin
        n_state       = r_state;
        n_status      = r_status;
        n_count       = r_count;
        n_ngrant      = r_ngrant;
        n_ign         = r_ign;
        n_pend_valid  = r_pend_valid;
        n_pend_client = r_pend_client;
        n_pend_count  = r_pend_count;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_grant   = r_out_grant;
        n_out_client  = r_out_client;
        n_out_ign     = r_out_ign;
        n_out_count   = r_out_count;
        n_out_last    = r_out_last;
        i_req.ready   = (r_state == rnfa_pkg::S_IDLE);

        unique case (r_state)
            rnfa_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (w_req_ok) begin
                        n_status[w_idx] = rnfa_pkg::ST_WAIT;
                        n_count         = r_count + 1'b1;
                    end
                    if (w_rel_ok) begin
                        n_status[w_idx] = rnfa_pkg::ST_THINK;
                    end
                    if (w_wdr_ok) begin
                        n_status[w_idx] = rnfa_pkg::ST_THINK;
                        n_count         = r_count - 1'b1;
                    end
                    n_ign        = !(w_req_ok || w_rel_ok || w_wdr_ok);
                    n_ngrant     = '0;
                    n_pend_valid = 1'b0;
                    n_state      = rnfa_pkg::S_SCAN;
                end
            end
            rnfa_pkg::S_SCAN: begin
                if (w_advance) begin
                    if (r_pend_valid) begin
                        n_out_valid  = 1'b1;
                        n_out_grant  = 1'b1;
                        n_out_client = ClientW'(r_pend_client);
                        n_out_ign    = r_ign;
                        n_out_count  = r_pend_count;
                        n_out_last   = !w_found;
                    end else if (!w_found) begin
                        n_out_valid  = 1'b1;
                        n_out_grant  = 1'b0;
                        n_out_client = '0;
                        n_out_ign    = r_ign;
                        n_out_count  = r_count;
                        n_out_last   = 1'b1;
                    end
                    if (w_found) begin
                        n_status[w_granted] = rnfa_pkg::ST_EAT;
                        n_count             = r_count - 1'b1;
                        n_ngrant            = r_ngrant + 1'b1;
                        n_pend_valid        = 1'b1;
                        n_pend_client       = w_granted;
                        n_pend_count        = r_count - 1'b1;
                    end else begin
                        n_pend_valid = 1'b0;
                        n_state      = rnfa_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = rnfa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rnfa_pkg::S_IDLE;
            r_count      <= '0;
            r_ngrant     <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < CLIENTS; k++) begin
                r_status[k] <= rnfa_pkg::ST_THINK;
            end
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_ngrant     <= n_ngrant;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_status     <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ign         <= n_ign;
        r_pend_client <= n_pend_client;
        r_pend_count  <= n_pend_count;
        r_out_grant   <= n_out_grant;
        r_out_client  <= n_out_client;
        r_out_ign     <= n_out_ign;
        r_out_count   <= n_out_count;
        r_out_last    <= n_out_last;
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.grant_valid    = r_out_grant;
    assign o_rsp.granted_client = r_out_client;
    assign o_rsp.ignored        = r_out_ign;
    assign o_rsp.queue_count    = CountW'(r_out_count);
    assign o_rsp.last           = r_out_last;

endmodule

### bench/ring_neighbour_fifo_arbiter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_neighbour_fifo_arbiter_tb: self-checking bench of the ring arbiter
// Drives request, release and withdraw events, mostly ones that fit the
// client's state, and predicts every grant result from a model of the ring.
// Sender and receiver idle at random, and one phase holds off the receiver
// long enough to stall the event channel.
// ----------------------------------------------------------------------------
module ring_neighbour_fifo_arbiter_tb;

    localparam int N_CLIENTS   = 5;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int OpW         = rnfa_pkg::OPCODE_W;
    localparam int ClientW     = rnfa_pkg::CLIENT_W;
    localparam int CountW      = rnfa_pkg::COUNT_W;

    localparam logic [OpW-1:0] OP_UNKNOWN = 2'd3;

    typedef struct packed {
        logic               grant_valid;
        logic [ClientW-1:0] granted_client;
        logic               ignored;
        logic [CountW-1:0]  queue_count;
        logic               last;
    } t_grant;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rnfa_in_if  req_if ();
    rnfa_out_if rsp_if ();

    ring_neighbour_fifo_arbiter #(
        .CLIENTS (N_CLIENTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    rnfa_pkg::t_status  seat [N_CLIENTS];
    logic [ClientW-1:0] wait_line [$];
    t_grant             grants_due [$];

    bit tx_stall  = 1'b0;
    bit rx_stall  = 1'b0;
    int hold_seq  = 0;
    int hold_seen = 0;

    int          errors      = 0;
    int          n_events    = 0;
    int          n_ignored   = 0;
    int          n_grants    = 0;
    int          n_multi     = 0;
    int          n_results   = 0;
    int unsigned cycle_count = 0;

    function automatic logic neighbours_free(input int c);
        int left;
        int right;
        left  = (c + N_CLIENTS - 1) % N_CLIENTS;
        right = (c + 1) % N_CLIENTS;
        return (seat[left] != rnfa_pkg::ST_EAT) && (seat[right] != rnfa_pkg::ST_EAT);
    endfunction

    // Apply one event to the ring and queue the results it causes: its grants, or one no-grant result.
    function automatic void apply_event(input logic [OpW-1:0] op,
                                        input logic [ClientW-1:0] c);
        logic               ign;
        logic [ClientW-1:0] who;
        int                 n;
        int                 p;
        bit                 found;
        t_grant             g;
        ign = 1'b1;
        n   = 0;
        if (c < N_CLIENTS) begin
            if (op == rnfa_pkg::OP_REQUEST && seat[c] == rnfa_pkg::ST_THINK
                && wait_line.size() < N_CLIENTS) begin
                seat[c] = rnfa_pkg::ST_WAIT;
                wait_line.push_back(c);
                ign = 1'b0;
            end else if (op == rnfa_pkg::OP_RELEASE && seat[c] == rnfa_pkg::ST_EAT) begin
                seat[c] = rnfa_pkg::ST_THINK;
                ign = 1'b0;
            end else if (op == rnfa_pkg::OP_WITHDRAW && seat[c] == rnfa_pkg::ST_WAIT) begin
                found = 1'b0;
                for (p = 0; p < wait_line.size() && !found; p++) begin
                    if (wait_line[p] == c) begin
                        wait_line.delete(p);
                        found = 1'b1;
                    end
                end
                seat[c] = rnfa_pkg::ST_THINK;
                ign = 1'b0;
            end
        end
        do begin
            found = 1'b0;
            for (p = 0; p < wait_line.size() && !found; p++) begin
                if (neighbours_free(wait_line[p])) begin
                    who = wait_line[p];
                    seat[who] = rnfa_pkg::ST_EAT;
                    wait_line.delete(p);
                    g.grant_valid    = 1'b1;
                    g.granted_client = who;
                    g.ignored        = ign;
                    g.queue_count    = CountW'(wait_line.size());
                    g.last           = 1'b0;
                    grants_due.push_back(g);
                    n++;
                    found = 1'b1;
                end
            end
        end while (found && n < rnfa_pkg::MAX_GRANTS);
        if (n == 0) begin
            g.grant_valid    = 1'b0;
            g.granted_client = '0;
            g.ignored        = ign;
            g.queue_count    = CountW'(wait_line.size());
            g.last           = 1'b1;
            grants_due.push_back(g);
        end else begin
            grants_due[grants_due.size() - 1].last = 1'b1;
        end
        n_events++;
        n_grants += n;
        if (ign)
            n_ignored++;
        if (n > 1)
            n_multi++;
    endfunction

    function automatic void check_result();
        t_grant got;
        t_grant want;
        got.grant_valid    = rsp_if.grant_valid;
        got.granted_client = rsp_if.granted_client;
        got.ignored        = rsp_if.ignored;
        got.queue_count    = rsp_if.queue_count;
        got.last           = rsp_if.last;
        n_results++;
        if (grants_due.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: unexpected result valid=%0b client=%0d ign=%0b count=%0d last=%0b",
                         $realtime, got.grant_valid, got.granted_client, got.ignored,
                         got.queue_count, got.last);
            return;
        end
        want = grants_due.pop_front();
        if (got.grant_valid !== want.grant_valid || got.granted_client !== want.granted_client ||
            got.ignored !== want.ignored || got.queue_count !== want.queue_count ||
            got.last !== want.last) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t: mismatch exp valid=%0b client=%0d ign=%0b count=%0d last=%0b",
                         $realtime, want.grant_valid, want.granted_client, want.ignored,
                         want.queue_count, want.last);
                $display("%0t:          got valid=%0b client=%0d ign=%0b count=%0d last=%0b",
                         $realtime, got.grant_valid, got.granted_client, got.ignored,
                         got.queue_count, got.last);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready)
                check_result();
            if (req_if.valid && req_if.ready)
                apply_event(req_if.opcode, req_if.client);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count,
                     grants_due.size());
            $display("[ring_neighbour_fifo_arbiter] ERROR");
            $finish;
        end
    end

    // Take results, idling between them at random while rx_stall is set; hold off for a long stretch on demand.
    initial begin : receiver
        int gap;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                rsp_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = rx_stall ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                rsp_if.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            rsp_if.ready = 1'b1;
            @(posedge i_clk);
            while (!(rsp_if.valid && i_rst_n)) @(posedge i_clk);
        end
    end

    task automatic send_event(input logic [OpW-1:0] op, input logic [ClientW-1:0] c);
        int gap;
        gap = tx_stall ? $urandom_range(0, 8) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.opcode = op;
        req_if.client = c;
        req_if.valid  = 1'b1;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (grants_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Mostly events that fit the client's state; some noise over all fields.
    task automatic pick_event(output logic [OpW-1:0] op, output logic [ClientW-1:0] c);
        int r;
        r = $urandom_range(0, 99);
        c = ClientW'($urandom_range(0, N_CLIENTS - 1));
        if (r < 15) begin
            op = OpW'($urandom_range(0, 3));
            c  = ClientW'($urandom_range(0, 15));
        end else begin
            if (seat[c] == rnfa_pkg::ST_WAIT && r >= 40)
                c = ClientW'($urandom_range(0, N_CLIENTS - 1));
            case (seat[c])
                rnfa_pkg::ST_THINK: op = rnfa_pkg::OP_REQUEST;
                rnfa_pkg::ST_WAIT:  op = rnfa_pkg::OP_WITHDRAW;
                default:  op = (r < 90) ? rnfa_pkg::OP_RELEASE : rnfa_pkg::OP_REQUEST;
            endcase
        end
    endtask

    task automatic test_directed();
        tx_stall = 1'b0;
        rx_stall = 1'b0;
        send_event(rnfa_pkg::OP_RELEASE, 4'd0);
        send_event(rnfa_pkg::OP_WITHDRAW, 4'd1);
        send_event(OP_UNKNOWN, 4'd2);
        send_event(rnfa_pkg::OP_REQUEST, 4'd15);
        send_event(rnfa_pkg::OP_REQUEST, ClientW'(N_CLIENTS));
        send_event(rnfa_pkg::OP_REQUEST, 4'd1);
        send_event(rnfa_pkg::OP_REQUEST, 4'd0);
        send_event(rnfa_pkg::OP_REQUEST, 4'd2);
        send_event(rnfa_pkg::OP_REQUEST, 4'd1);
        send_event(rnfa_pkg::OP_REQUEST, 4'd0);
        send_event(rnfa_pkg::OP_WITHDRAW, 4'd1);
        send_event(rnfa_pkg::OP_RELEASE, 4'd1);
        send_event(rnfa_pkg::OP_WITHDRAW, 4'd0);
        send_event(rnfa_pkg::OP_REQUEST, 4'd1);
        send_event(rnfa_pkg::OP_REQUEST, 4'd4);
        send_event(rnfa_pkg::OP_REQUEST, 4'd3);
        send_event(rnfa_pkg::OP_WITHDRAW, 4'd4);
        send_event(rnfa_pkg::OP_RELEASE, 4'd0);
        send_event(rnfa_pkg::OP_RELEASE, 4'd2);
        send_event(rnfa_pkg::OP_RELEASE, 4'd1);
        send_event(rnfa_pkg::OP_RELEASE, 4'd3);
        send_event(rnfa_pkg::OP_RELEASE, 4'd14);
        send_event(OP_UNKNOWN, 4'd15);
        wait_idle();
    endtask

    task automatic test_random(input int count, input bit tx, input bit rx);
        logic [OpW-1:0]     op;
        logic [ClientW-1:0] c;
        int                 k;
        tx_stall = tx;
        rx_stall = rx;
        for (k = 0; k < count; k++) begin
            pick_event(op, c);
            send_event(op, c);
            if ($urandom_range(0, 39) == 0)
                wait_idle();
        end
        wait_idle();
    endtask

    // Hold off the receiver while events keep coming, so the arbiter stalls.
    task automatic test_backpressure();
        logic [OpW-1:0]     op;
        logic [ClientW-1:0] c;
        int                 k;
        tx_stall = 1'b0;
        rx_stall = 1'b0;
        hold_seq++;
        for (k = 0; k < 20; k++) begin
            pick_event(op, c);
            send_event(op, c);
        end
        wait_idle();
    endtask

    initial begin : main
        int k;
        req_if.valid  = 1'b0;
        req_if.opcode = rnfa_pkg::OP_REQUEST;
        req_if.client = '0;
        i_rst_n       = 1'b0;
        for (k = 0; k < N_CLIENTS; k++)
            seat[k] = rnfa_pkg::ST_THINK;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(200, 1'b1, 1'b1);
        test_backpressure();
        test_random(100, 1'b0, 1'b0);
        test_random(120, 1'b1, 1'b0);
        test_random(20, 1'b0, 1'b1);

        $display("covered %0d events (%0d ignored) giving %0d results with %0d grants,",
                 n_events, n_ignored, n_results, n_grants);
        $display("%0d events granting several clients, random idling and one long stall",
                 n_multi);
        if (errors == 0) begin
            $display("[ring_neighbour_fifo_arbiter] OK");
        end else begin
            $display("%0d errors", errors);
            $display("[ring_neighbour_fifo_arbiter] ERROR");
        end
        $finish;
    end

endmodule
